/* rtl/dps_pkg.sv */
// ----------------------------------------------------------------------------
// Deadline profit scheduler package
// Field widths, limits and the types shared by the scheduler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dps_pkg;

	localparam int PROFIT_W   = 16;
	localparam int DEADLINE_W = 6;
	localparam int VALUE_W    = 21;

	localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

	localparam logic KIND_SLOT  = 1'b0;
	localparam logic KIND_TOTAL = 1'b1;

	typedef struct packed {
		logic [PROFIT_W-1:0]   profit;
		logic [DEADLINE_W-1:0] deadline;
	} task_t;

	typedef struct packed {
		logic insert;
		logic drain;
	} cell_cmd_t;

	typedef struct packed {
		logic  place;
		logic  clear;
		task_t item;
	} place_cmd_t;

endpackage

`default_nettype wire

/* rtl/dps_task_if.sv */
// ----------------------------------------------------------------------------
// Task channel
// Valid/ready channel that carries one task per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface dps_task_if import dps_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [PROFIT_W-1:0]   profit;
	logic [DEADLINE_W-1:0] deadline;
	logic                  last_task;

	modport source (output valid, output profit, output deadline, output last_task,
		input ready);
	modport sink (input valid, input profit, input deadline, input last_task,
		output ready);
endinterface

`default_nettype wire

/* rtl/dps_result_if.sv */
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one scheduled profit or the total.
// ----------------------------------------------------------------------------
`default_nettype none

interface dps_result_if import dps_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               kind;
	logic [VALUE_W-1:0] value;
	logic               overflow;
	logic               last_result;

	modport source (output valid, output kind, output value, output overflow,
		output last_result, input ready);
	modport sink (input valid, input kind, input value, input overflow,
		input last_result, output ready);
endinterface

`default_nettype wire

/* rtl/dps_cell.sv */
// ----------------------------------------------------------------------------
// Sorting cell
// Holds one task of the profit-ordered chain and trades it with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module dps_cell import dps_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  cell_cmd_t  cmd,
	input  task_t      new_task,
	input  wire        prev_ins,
	input  wire        prev_valid,
	input  task_t      prev_task,
	input  wire        next_valid,
	input  task_t      next_task,
	output logic       ins,
	output logic       valid,
	output task_t      data
);

	logic  valid_q;
	task_t data_q;

	// A new task goes in front of every stored task with a strictly lower profit.
	assign ins   = !valid_q || (new_task.profit > data_q.profit);
	assign valid = valid_q;
	assign data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.drain) begin
			valid_q <= next_valid;
		end else if (cmd.insert && ins) begin
			valid_q <= prev_ins ? prev_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.drain) begin
			data_q <= next_task;
		end else if (cmd.insert && ins) begin
			data_q <= prev_ins ? prev_task : new_task;
		end
	end

endmodule

`default_nettype wire

/* rtl/dps_chain.sv */
// ----------------------------------------------------------------------------
// Sorting chain
// Row of sorting cells that keeps the stored tasks in falling profit order.
// ----------------------------------------------------------------------------
`default_nettype none

module dps_chain import dps_pkg::*; #(
	parameter int MAX_TASKS = 64
) (
	input  wire        clk,
	input  wire        arst_n,
	input  cell_cmd_t  cmd,
	input  task_t      new_task,
	output logic       head_valid,
	output task_t      head,
	output logic       full
);

	logic  ins_w   [MAX_TASKS];
	logic  valid_w [MAX_TASKS];
	task_t data_w  [MAX_TASKS];

	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		logic  p_ins, p_valid, n_valid;
		task_t p_task, n_task;

		if (i == 0) begin : g_first
			assign p_ins   = 1'b0;
			assign p_valid = 1'b0;
			assign p_task  = '0;
		end else begin : g_inner
			assign p_ins   = ins_w[i-1];
			assign p_valid = valid_w[i-1];
			assign p_task  = data_w[i-1];
		end

		if (i == MAX_TASKS - 1) begin : g_last
			assign n_valid = 1'b0;
			assign n_task  = '0;
		end else begin : g_mid
			assign n_valid = valid_w[i+1];
			assign n_task  = data_w[i+1];
		end

		dps_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.new_task   (new_task),
			.prev_ins   (p_ins),
			.prev_valid (p_valid),
			.prev_task  (p_task),
			.next_valid (n_valid),
			.next_task  (n_task),
			.ins        (ins_w[i]),
			.valid      (valid_w[i]),
			.data       (data_w[i])
		);
	end

	assign head_valid = valid_w[0];
	assign head       = data_w[0];
	assign full       = valid_w[MAX_TASKS-1];

endmodule

`default_nettype wire

/* rtl/dps_placer.sv */
// ----------------------------------------------------------------------------
// Slot placer
// Slot table, latest-free-slot search and running total of placed profits.
// ----------------------------------------------------------------------------
`default_nettype none

module dps_placer import dps_pkg::*; #(
	parameter int MAX_SLOTS = 32,
	localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  place_cmd_t          cmd,
	input  wire  [SLOT_W-1:0]   scan_idx,
	output logic                scan_used,
	output logic [PROFIT_W-1:0] scan_profit,
	output logic [VALUE_W-1:0]  total
);

	localparam logic [DEADLINE_W-1:0] SLOTS_D = DEADLINE_W'(MAX_SLOTS);

	logic [MAX_SLOTS-1:0] used_q;
	logic [PROFIT_W-1:0]  profit_q [MAX_SLOTS];
	logic [VALUE_W-1:0]   total_q;

	logic [DEADLINE_W-1:0] limit;
	logic                  found;
	logic [SLOT_W-1:0]     fidx;
	logic [VALUE_W:0]      sum;
	logic [VALUE_W-1:0]    sum_sat;

	assign limit = (cmd.item.deadline > SLOTS_D) ? SLOTS_D : cmd.item.deadline;

	always_comb begin
		found = 1'b0;
		fidx  = '0;
		for (int s = 0; s < MAX_SLOTS; s++) begin
			if (!used_q[s] && (DEADLINE_W'(s) < limit)) begin
				found = 1'b1;
				fidx  = SLOT_W'(s);
			end
		end
	end

	assign sum     = {1'b0, total_q} + (VALUE_W+1)'(cmd.item.profit);
	assign sum_sat = (sum > {1'b0, VALUE_MAX}) ? VALUE_MAX : sum[VALUE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			total_q <= '0;
		end else if (cmd.clear) begin
			used_q  <= '0;
			total_q <= '0;
		end else if (cmd.place && found) begin
			used_q[fidx] <= 1'b1;
			total_q      <= sum_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.place && found) begin
			profit_q[fidx] <= cmd.item.profit;
		end
	end

	assign scan_used   = used_q[scan_idx];
	assign scan_profit = profit_q[scan_idx];
	assign total       = total_q;

endmodule

`default_nettype wire

/* rtl/deadline_profit_scheduler.sv */
// ----------------------------------------------------------------------------
// Deadline profit scheduler
// Greedy job sequencing with deadlines over a profit-sorted cell chain.
// ----------------------------------------------------------------------------
// Tasks are accepted one per cycle while a set is loading; each one is sorted
// into a chain of MAX_TASKS cells as it arrives, and a full chain drops further
// tasks and flags overflow. After the transaction that carries last_task the
// chain drains one task per cycle into the slot search. The slot table is then
// scanned from the top slot down, one slot per cycle while the result channel
// accepts, and the total follows the last slot. New tasks are accepted again as
// soon as the total is in the output register.
`default_nettype none

module deadline_profit_scheduler import dps_pkg::*; #(
	parameter int MAX_TASKS = 64,
	parameter int MAX_SLOTS = 32
) (
	input wire           clk,
	input wire           arst_n,
	dps_task_if.sink     jobs,
	dps_result_if.source results
);

	localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(MAX_SLOTS - 1);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_PLACE,
		ST_EMIT,
		ST_TOTAL
	} state_t;

	state_t             state_q;
	logic [SLOT_W-1:0]  scan_q;
	logic               overflow_q;
	logic               out_valid_q;
	logic               out_kind_q;
	logic [VALUE_W-1:0] out_value_q;
	logic               out_last_q;

	logic                accept;
	logic                out_free;
	cell_cmd_t           chain_cmd;
	place_cmd_t          place_cmd;
	task_t               new_task;
	logic                head_valid;
	task_t               head;
	logic                full;
	logic                scan_used;
	logic [PROFIT_W-1:0] scan_profit;
	logic [VALUE_W-1:0]  total;

	assign jobs.ready = (state_q == ST_LOAD);
	assign accept     = jobs.valid && jobs.ready;
	assign out_free   = !out_valid_q || results.ready;

	assign new_task.profit   = jobs.profit;
	assign new_task.deadline = jobs.deadline;

	assign chain_cmd.insert = accept && !full;
	assign chain_cmd.drain  = (state_q == ST_PLACE) && head_valid;

	assign place_cmd.place = (state_q == ST_PLACE) && head_valid;
	assign place_cmd.clear = (state_q == ST_TOTAL) && out_free;
	assign place_cmd.item  = head;

	dps_chain #(
		.MAX_TASKS (MAX_TASKS)
	) u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (chain_cmd),
		.new_task   (new_task),
		.head_valid (head_valid),
		.head       (head),
		.full       (full)
	);

	dps_placer #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_placer (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (place_cmd),
		.scan_idx    (scan_q),
		.scan_used   (scan_used),
		.scan_profit (scan_profit),
		.total       (total)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			scan_q      <= '0;
			overflow_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_SLOT;
			out_value_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_valid_q && results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (full) begin
							overflow_q <= 1'b1;
						end
						if (jobs.last_task) begin
							state_q <= ST_PLACE;
						end
					end
				end
				ST_PLACE: begin
					if (!head_valid) begin
						scan_q  <= SLOT_TOP;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (scan_used) begin
							out_valid_q <= 1'b1;
							out_kind_q  <= KIND_SLOT;
							out_value_q <= VALUE_W'(scan_profit);
							out_last_q  <= 1'b0;
						end
						if (scan_q == '0) begin
							state_q <= ST_TOTAL;
						end else begin
							scan_q <= scan_q - 1'b1;
						end
					end
				end
				ST_TOTAL: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= KIND_TOTAL;
						out_value_q <= total;
						out_last_q  <= 1'b1;
						overflow_q  <= 1'b0;
						state_q     <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// The overflow flag of an output stays with the set it belongs to.
	logic out_overflow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_overflow_q <= 1'b0;
		end else if ((state_q == ST_EMIT && out_free && scan_used) ||
			(state_q == ST_TOTAL && out_free)) begin
			out_overflow_q <= overflow_q;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.kind        = out_kind_q;
	assign results.value       = out_value_q;
	assign results.overflow    = out_overflow_q;
	assign results.last_result = out_last_q;

endmodule

`default_nettype wire

/* rtl/dps_checker.sv */
// ----------------------------------------------------------------------------
// Scheduler port checker
// Concurrent assertions on the scheduler ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dps_checker import dps_pkg::*; (
	input wire               clk,
	input wire               arst_n,
	input wire               in_valid,
	input wire               in_ready,
	input wire               in_last_task,
	input wire               out_valid,
	input wire               out_ready,
	input wire               out_kind,
	input wire [VALUE_W-1:0] out_value,
	input wire               out_last_result
);

	// A stalled result transaction holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_kind))
		else $error("stalled result changed");

	// After the final task of a set the scheduler drops ready and takes no task until results are out.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last_task |=> !in_ready)
		else $error("task accepted during scheduling");

	// Only the total ends a run.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_kind == out_last_result))
		else $error("last_result does not match kind");

	// A slot result carries the profit of a single task.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == KIND_SLOT) |-> (out_value[VALUE_W-1:PROFIT_W] == '0))
		else $error("slot result wider than a task profit");

endmodule

bind deadline_profit_scheduler dps_checker u_dps_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (jobs.valid),
	.in_ready        (jobs.ready),
	.in_last_task    (jobs.last_task),
	.out_valid       (results.valid),
	.out_ready       (results.ready),
	.out_kind        (results.kind),
	.out_value       (results.value),
	.out_last_result (results.last_result)
);

`default_nettype wire

/* tb/tb_deadline_profit_scheduler.sv */
// ----------------------------------------------------------------------------
// Deadline profit scheduler testbench
// Drives sets of tasks into the scheduler and checks every scheduled profit
// and every total against a greedy job sequencing predictor in the bench. The
// run starts with short directed sets, covering extreme fields, deadline zero,
// saturated deadlines and equal profits. Random sets follow, including a set
// that fills the task store exactly and one that overflows it. Both channels
// idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_deadline_profit_scheduler;
	import dps_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TASK_CAP   = 64;
	localparam int SLOT_CNT   = 32;
	localparam int JOB_TARGET = 310;
	localparam int MAX_GAP    = 13;
	localparam int CYCLE_CAP  = 300000;
	localparam int DRAIN_WAIT = TASK_CAP + SLOT_CNT + 40;

	typedef struct {
		logic [PROFIT_W-1:0]   profit;
		logic [DEADLINE_W-1:0] deadline;
		logic                  last_task;
		int                    gap;
	} job_item_t;

	typedef struct {
		logic               kind;
		logic [VALUE_W-1:0] value;
		logic               overflow;
		logic               last_result;
	} sched_result_t;

	logic clk;
	logic arst_n;

	dps_task_if   jobs_if ();
	dps_result_if res_if ();

	deadline_profit_scheduler #(
		.MAX_TASKS(TASK_CAP),
		.MAX_SLOTS(SLOT_CNT)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.jobs   (jobs_if),
		.results(res_if)
	);

	job_item_t     pending_jobs[$];
	sched_result_t expected_results[$];

	logic [PROFIT_W-1:0]   held_profit[TASK_CAP];
	logic [DEADLINE_W-1:0] held_deadline[TASK_CAP];
	int                    held_count;
	logic                  set_overflow;

	int jobs_total;
	int jobs_taken;
	int results_seen;
	int slot_results;
	int sets_scheduled;
	int overflow_sets;
	int mismatches;
	int cycle_count;

	logic      job_fire;
	logic      res_fire;
	logic      job_staged;
	int        job_hold;
	job_item_t staged_job;
	int        res_stall;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic add_job(input logic [PROFIT_W-1:0] profit,
		input logic [DEADLINE_W-1:0] deadline, input logic last_task);
		job_item_t item;
		item.profit    = profit;
		item.deadline  = deadline;
		item.last_task = last_task;
		item.gap       = ((pending_jobs.size() / 30) % 4 == 3) ? 0 : $urandom_range(0, MAX_GAP);
		pending_jobs.insert(pending_jobs.size(), item);
	endtask

	function automatic logic [PROFIT_W-1:0] draw_profit();
		if ($urandom_range(0, 2) == 0)
			return PROFIT_W'($urandom_range(0, 3) * 1000);
		return PROFIT_W'($urandom());
	endfunction

	function automatic logic [DEADLINE_W-1:0] draw_deadline(input int spread);
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return DEADLINE_W'($urandom_range(SLOT_CNT + 1, 63));
		return DEADLINE_W'($urandom_range(1, spread));
	endfunction

	task automatic add_random_set(input int size, input int spread);
		int i;
		for (i = 0; i < size; i++)
			add_job(draw_profit(), draw_deadline(spread), i == size - 1);
	endtask

	// Greedy placement of a completed set: falling profit, equal profits kept
	// in arrival order, each task in the latest free slot below its deadline.
	task automatic schedule_task(input logic [PROFIT_W-1:0] profit,
		input logic [DEADLINE_W-1:0] deadline, input logic last_task);
		int                  order[TASK_CAP];
		logic [PROFIT_W-1:0] slot_profit[SLOT_CNT];
		logic [SLOT_CNT-1:0] slot_used;
		int                  total;
		int                  i;
		int                  j;
		int                  d;
		sched_result_t       r;
		if (held_count < TASK_CAP) begin
			held_profit[held_count]   = profit;
			held_deadline[held_count] = deadline;
			held_count++;
		end else begin
			set_overflow = 1'b1;
		end
		if (!last_task)
			return;
		for (i = 0; i < held_count; i++) begin
			j = i;
			while (j > 0 && held_profit[order[j-1]] < held_profit[i]) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = i;
		end
		slot_used = '0;
		total = 0;
		for (i = 0; i < held_count; i++) begin
			d = (held_deadline[order[i]] > SLOT_CNT) ? SLOT_CNT : held_deadline[order[i]];
			while (d > 0) begin
				d--;
				if (!slot_used[d]) begin
					slot_used[d]   = 1'b1;
					slot_profit[d] = held_profit[order[i]];
					total += held_profit[order[i]];
					break;
				end
			end
		end
		if (total > VALUE_MAX)
			total = VALUE_MAX;
		for (i = SLOT_CNT - 1; i >= 0; i--) begin
			if (slot_used[i]) begin
				r.kind        = KIND_SLOT;
				r.value       = VALUE_W'(slot_profit[i]);
				r.overflow    = set_overflow;
				r.last_result = 1'b0;
				expected_results.insert(expected_results.size(), r);
			end
		end
		r.kind        = KIND_TOTAL;
		r.value       = VALUE_W'(total);
		r.overflow    = set_overflow;
		r.last_result = 1'b1;
		expected_results.insert(expected_results.size(), r);
		sets_scheduled++;
		if (set_overflow)
			overflow_sets++;
		held_count   = 0;
		set_overflow = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		sched_result_t want;
		if (!arst_n) begin
			job_fire <= 1'b0;
			res_fire <= 1'b0;
		end else begin
			job_fire <= jobs_if.valid && jobs_if.ready;
			res_fire <= res_if.valid && res_if.ready;
			if (jobs_if.valid && jobs_if.ready) begin
				schedule_task(jobs_if.profit, jobs_if.deadline, jobs_if.last_task);
				jobs_taken++;
			end
			if (res_if.valid && res_if.ready) begin
				results_seen++;
				if (res_if.kind == KIND_SLOT)
					slot_results++;
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result kind=%0b value=%0d overflow=%0b last=%0b",
						$time, res_if.kind, res_if.value, res_if.overflow, res_if.last_result);
				end else begin
					want = expected_results.pop_front();
					if (res_if.kind !== want.kind || res_if.value !== want.value ||
						res_if.overflow !== want.overflow ||
						res_if.last_result !== want.last_result) begin
						mismatches++;
						$display("%0t: expected kind=%0b value=%0d overflow=%0b last=%0b",
							$time, want.kind, want.value, want.overflow, want.last_result);
						$display("%0t: actual   kind=%0b value=%0d overflow=%0b last=%0b",
							$time, res_if.kind, res_if.value, res_if.overflow,
							res_if.last_result);
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!jobs_if.valid || job_fire)) begin
			if (!job_staged && pending_jobs.size() > 0) begin
				staged_job = pending_jobs.pop_front();
				job_staged = 1'b1;
				job_hold   = staged_job.gap;
			end
			if (job_staged && job_hold == 0) begin
				jobs_if.valid     <= 1'b1;
				jobs_if.profit    <= staged_job.profit;
				jobs_if.deadline  <= staged_job.deadline;
				jobs_if.last_task <= staged_job.last_task;
				job_staged = 1'b0;
			end else begin
				jobs_if.valid <= 1'b0;
				if (job_staged)
					job_hold--;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (res_fire)
				res_stall = ((results_seen / 25) % 3 == 2) ? 0 : $urandom_range(0, MAX_GAP);
			if (res_stall > 0) begin
				res_if.ready <= 1'b0;
				res_stall--;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("%0t: run stopped after %0d cycles, %0d of %0d tasks taken, %0d results owed",
				$time, cycle_count, jobs_taken, jobs_total, expected_results.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int spread;
		arst_n            = 1'b0;
		jobs_if.valid     = 1'b0;
		jobs_if.profit    = '0;
		jobs_if.deadline  = '0;
		jobs_if.last_task = 1'b0;
		res_if.ready      = 1'b0;
		held_count        = 0;
		set_overflow      = 1'b0;
		jobs_taken        = 0;
		results_seen      = 0;
		slot_results      = 0;
		sets_scheduled    = 0;
		overflow_sets     = 0;
		mismatches        = 0;
		cycle_count       = 0;
		job_staged        = 1'b0;
		job_hold          = 0;
		res_stall         = 0;

		add_job(16'hFFFF, 6'd32, 1'b1);
		add_job(16'h0000, 6'd0, 1'b1);
		add_job(16'h1234, 6'd63, 1'b1);
		add_job(16'h0000, 6'd1, 1'b0);
		add_job(16'hFFFF, 6'd1, 1'b0);
		add_job(16'h0007, 6'd2, 1'b1);
		add_job(16'd500, 6'd2, 1'b0);
		add_job(16'd500, 6'd1, 1'b0);
		add_job(16'd500, 6'd2, 1'b0);
		add_job(16'd300, 6'd3, 1'b1);
		add_job(16'hAAAA, 6'd33, 1'b0);
		add_job(16'h5555, 6'd32, 1'b0);
		add_job(16'h8001, 6'd0, 1'b1);
		add_job(16'h7FFE, 6'd31, 1'b0);
		add_job(16'h0001, 6'd31, 1'b1);

		while (pending_jobs.size() < JOB_TARGET) begin
			if (pending_jobs.size() > 90 && pending_jobs.size() < 110) begin
				add_random_set(TASK_CAP, 63);
			end else if (pending_jobs.size() > 190 && pending_jobs.size() < 230) begin
				add_random_set(TASK_CAP + 2, 63);
			end else begin
				spread = ($urandom_range(0, 3) == 0) ? 40 : 8;
				add_random_set($urandom_range(1, 10), spread);
			end
		end
		jobs_total = pending_jobs.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (jobs_taken < jobs_total || expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);

		$display("Checked %0d tasks in %0d sets (%0d with store overflow).",
			jobs_taken, sets_scheduled, overflow_sets);
		$display("Compared %0d results, %0d of them slot profits, in %0d cycles.",
			results_seen, slot_results, cycle_count);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire
